[rtl/core/sca_pkg.sv]
// Shared types, codes and class tables of the slab allocator.
`timescale 1ns / 1ps
package sca_pkg;

  localparam int unsigned NumClasses = 19;
  localparam int unsigned NumZones   = 4;
  localparam int unsigned ItemIdxW   = 13;
  localparam logic [15:0] NoItem     = 16'hFFFF;
  localparam logic [23:0] MaxRequest = 24'd2097152;
  localparam logic        KindFree   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_SPACE   = 2'd1,
    STATUS_TOO_LARGE  = 2'd2,
    STATUS_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SEC_RD, S_SEC_CHK, S_BLK_INIT, S_BLK_RD, S_BLK_CHK,
    S_LINK_RD, S_LINK_USE, S_TAKE, S_APP_RD, S_APP_W1, S_APP_W2, S_RESP
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_DECODE, OP_SEC_RD, OP_SEC_CHK, OP_BLK_INIT, OP_BLK_RD,
    OP_BLK_CHK, OP_LINK_RD, OP_LINK_USE, OP_TAKE, OP_APP_RD, OP_APP_W1, OP_APP_W2,
    OP_RESP
  } op_e;

  typedef struct packed {
    logic is_free;
    logic too_large;
    logic head_hit;
    logic act_hit;
    logic sec_avail;
    logic sec_ok;
    logic blk_ok;
    logic fh_hit;
    logic bump_ok;
    logic item_ok;
    logic was_full;
    logic ring_live;
    logic out_free;
  } dp_status_t;

  function automatic logic [1:0] class_zone(input logic [4:0] cls);
    logic [1:0] z;
    if (cls < 5'd12)      z = 2'd0;
    else if (cls < 5'd14) z = 2'd1;
    else if (cls < 5'd16) z = 2'd2;
    else                  z = 2'd3;
    return z;
  endfunction

  function automatic logic [4:0] zone_shift(input logic [1:0] z);
    logic [4:0] s;
    unique case (z)
      2'd0:    s = 5'd16;
      2'd1:    s = 5'd18;
      2'd2:    s = 5'd20;
      default: s = 5'd22;
    endcase
    return s;
  endfunction

  function automatic logic [13:0] items_per_block(input logic [4:0] cls);
    logic [4:0] sh;
    sh = zone_shift(class_zone(cls)) - cls - 5'd3;
    return 14'd1 << sh;
  endfunction

  // smallest class whose item size covers the request
  function automatic logic [4:0] size_class(input logic [23:0] sz);
    logic [4:0] c;
    c = 5'd18;
    for (int i = 18; i >= 0; i--) begin
      if ({1'b0, sz} <= (25'd8 << i)) c = 5'(i);
    end
    return c;
  endfunction

endpackage

[rtl/core/sca_if.sv]
// Request and response channel interfaces of the slab allocator.
`timescale 1ns / 1ps
interface sca_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [23:0] request_size;
  logic [31:0] free_handle;
  modport source (output valid, kind, request_size, free_handle, input ready);
  modport sink   (input valid, kind, request_size, free_handle, output ready);
endinterface

interface sca_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] handle;
  logic [23:0] byte_offset;
  modport source (output valid, status, handle, byte_offset, input ready);
  modport sink   (input valid, status, handle, byte_offset, output ready);
endinterface

[rtl/core/sca_ctrl.sv]
// Request sequencer of the slab allocator.
`timescale 1ns / 1ps
module sca_ctrl
  import sca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output op_e        op_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        if (status_i.is_free)                          state_d = status_i.sec_ok ? S_SEC_RD : S_RESP;
        else if (status_i.too_large)                   state_d = S_RESP;
        else if (status_i.head_hit)                    state_d = S_BLK_RD;
        else if (status_i.act_hit || status_i.sec_avail) state_d = S_SEC_RD;
        else                                           state_d = S_RESP;
      end
      S_SEC_RD:   state_d = S_SEC_CHK;
      S_SEC_CHK: begin
        if (status_i.is_free) state_d = status_i.blk_ok ? S_BLK_RD : S_RESP;
        else                  state_d = S_BLK_INIT;
      end
      S_BLK_INIT: state_d = S_BLK_RD;
      S_BLK_RD:   state_d = S_BLK_CHK;
      S_BLK_CHK: begin
        if (status_i.is_free) begin
          state_d = (status_i.item_ok && status_i.was_full && status_i.ring_live)
                    ? S_APP_RD : S_RESP;
        end else if (status_i.fh_hit) state_d = S_LINK_RD;
        else if (status_i.bump_ok)    state_d = S_TAKE;
        else                          state_d = S_RESP;
      end
      S_LINK_RD:  state_d = S_LINK_USE;
      S_LINK_USE: state_d = S_TAKE;
      S_TAKE:     state_d = S_RESP;
      S_APP_RD:   state_d = S_APP_W1;
      S_APP_W1:   state_d = S_APP_W2;
      S_APP_W2:   state_d = S_RESP;
      S_RESP:     if (status_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_ACCEPT;
      end
      S_DECODE:   op_o = OP_DECODE;
      S_SEC_RD:   op_o = OP_SEC_RD;
      S_SEC_CHK:  op_o = OP_SEC_CHK;
      S_BLK_INIT: op_o = OP_BLK_INIT;
      S_BLK_RD:   op_o = OP_BLK_RD;
      S_BLK_CHK:  op_o = OP_BLK_CHK;
      S_LINK_RD:  op_o = OP_LINK_RD;
      S_LINK_USE: op_o = OP_LINK_USE;
      S_TAKE:     op_o = OP_TAKE;
      S_APP_RD:   op_o = OP_APP_RD;
      S_APP_W1:   op_o = OP_APP_W1;
      S_APP_W2:   op_o = OP_APP_W2;
      S_RESP:     op_o = OP_RESP;
      default:    op_o = OP_NONE;
    endcase
  end

endmodule

[rtl/core/sca_dp.sv]
// Datapath of the slab allocator: tables, block memories and result register.
`timescale 1ns / 1ps
module sca_dp
  import sca_pkg::*;
#(
  parameter int unsigned NUM_SECTIONS  = 4,
  parameter int unsigned SECTION_SHIFT = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  op_e         op_i,
  input  logic        in_kind_i,
  input  logic [23:0] in_size_i,
  input  logic [31:0] in_handle_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  out_status_o,
  output logic [31:0] out_handle_o,
  output logic [23:0] out_offset_o,
  output dp_status_t  status_o
);

  localparam int unsigned BPW  = SECTION_SHIFT - 16;
  localparam int unsigned BPS  = 1 << BPW;
  localparam int unsigned SECW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int unsigned GW   = SECW + BPW;
  localparam int unsigned TB   = NUM_SECTIONS * BPS;
  localparam int unsigned NSW  = $clog2(NUM_SECTIONS + 1);
  localparam int unsigned SNW  = BPW + 1;
  localparam int unsigned LW   = GW + ItemIdxW;

  // control state
  logic [2:0]     sec_in_use_q;
  logic [NSW-1:0] next_sec_q;
  logic           act_v_q  [NumZones];
  logic           head_v_q [NumClasses];
  logic           rsp_valid_q;

  // payload
  logic           kind_q;
  logic [23:0]    size_q;
  logic [31:0]    hnd_q;
  logic [4:0]     cls_q;
  logic [GW-1:0]  g_q;
  logic [SECW-1:0] s_q;
  logic           new_q;
  logic [15:0]    item_q;
  status_e        err_q;
  logic [SECW-1:0] act_q  [NumZones];
  logic [GW-1:0]  head_q [NumClasses];
  logic [1:0]     rsp_status_q;
  logic [31:0]    rsp_handle_q;
  logic [23:0]    rsp_offset_q;

  // memories and registered read data
  logic [GW-1:0]  next_mem [TB];
  logic [GW-1:0]  prev_mem [TB];
  logic [15:0]    fh_mem   [TB];
  logic [13:0]    bump_mem [TB];
  logic [13:0]    cnt_mem  [TB];
  logic [4:0]     cls_mem  [TB];
  logic [15:0]    link_mem [TB * (1 << ItemIdxW)];
  logic [SNW-1:0] sn_mem   [NUM_SECTIONS];
  logic [GW-1:0]  next_rd_q, prev_rd_q;
  logic [15:0]    fh_rd_q, link_rd_q;
  logic [13:0]    bump_rd_q, cnt_rd_q;
  logic [4:0]     cls_rd_q;
  logic [SNW-1:0] sn_rd_q;

  // decode
  logic [7:0]     hsec, hblk;
  logic [4:0]     cls_calc, cls_fr;
  logic [1:0]     zc, zq;
  logic           is_free, too_large, head_hit, act_hit, sec_avail, sec_ok, blk_ok;
  logic [SNW-1:0] b, b_inc, nblk;
  logic [GW-1:0]  g_new, g_free, h_ptr;
  logic [13:0]    ipb_q, ipb_fr, cnt_inc;
  logic           fh_hit, bump_ok, item_ok, was_full, ring_live, will_fill, out_free;
  logic           app_empty;
  logic [7:0]     sec8, blk8;
  logic [31:0]    off_sum;

  assign hsec      = hnd_q[31:24];
  assign hblk      = hnd_q[23:16];
  assign is_free   = (kind_q == KindFree);
  assign cls_calc  = size_class(size_q);
  assign too_large = size_q > MaxRequest;
  assign zc        = class_zone(cls_calc);
  assign zq        = class_zone(cls_q);
  assign head_hit  = head_v_q[cls_calc];
  assign act_hit   = act_v_q[zc];
  assign sec_avail = (9'(next_sec_q) < 9'(sec_in_use_q)) && (9'(next_sec_q) < 9'(NUM_SECTIONS));
  assign sec_ok    = (9'(hsec) < 9'(next_sec_q)) && (9'(hsec) < 9'(NUM_SECTIONS));
  assign blk_ok    = 9'(hblk) < 9'(sn_rd_q);
  assign b         = new_q ? '0 : sn_rd_q;
  assign b_inc     = b + SNW'(1);
  assign nblk      = SNW'(1) << (5'(SECTION_SHIFT) - zone_shift(zq));
  assign g_new     = {s_q, b[BPW-1:0]};
  assign g_free    = {hsec[SECW-1:0], hblk[BPW-1:0]};
  assign h_ptr     = head_q[cls_q];
  assign ipb_q     = items_per_block(cls_q);
  assign cls_fr    = (cls_rd_q >= 5'(NumClasses)) ? cls_rd_q - 5'(NumClasses) : cls_rd_q;
  assign ipb_fr    = items_per_block(cls_fr);
  assign fh_hit    = fh_rd_q != NoItem;
  assign bump_ok   = bump_rd_q < ipb_q;
  assign item_ok   = (hnd_q[15:0] < {2'b00, bump_rd_q}) && (cnt_rd_q != 14'd0);
  assign was_full  = cnt_rd_q >= ipb_fr;
  assign ring_live = head_v_q[cls_fr];
  assign cnt_inc   = cnt_rd_q + 14'd1;
  assign will_fill = cnt_inc >= ipb_q;
  assign out_free  = !rsp_valid_q || out_ready_i;
  // freed block was full and its class ring is empty: it starts a ring of one
  assign app_empty = is_free && item_ok && was_full && !ring_live;

  assign sec8    = 8'(g_q >> BPW);
  assign blk8    = 8'(g_q[BPW-1:0]);
  assign off_sum = ({24'd0, sec8} << SECTION_SHIFT)
                 + ({24'd0, blk8} << zone_shift(zq))
                 + ({16'd0, item_q} << (cls_q + 5'd3));

  assign status_o = '{is_free: is_free, too_large: too_large, head_hit: head_hit,
                      act_hit: act_hit, sec_avail: sec_avail, sec_ok: sec_ok,
                      blk_ok: blk_ok, fh_hit: fh_hit, bump_ok: bump_ok,
                      item_ok: item_ok, was_full: was_full, ring_live: ring_live,
                      out_free: out_free};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_in_use_q <= 3'd4;
      next_sec_q   <= '0;
      rsp_valid_q  <= 1'b0;
      for (int i = 0; i < NumZones; i++)   act_v_q[i]  <= 1'b0;
      for (int i = 0; i < NumClasses; i++) head_v_q[i] <= 1'b0;
    end else begin
      if (cfg_we_i) sec_in_use_q <= cfg_wdata_i;
      if (op_i == OP_RESP && out_free) rsp_valid_q <= 1'b1;
      else if (out_ready_i)            rsp_valid_q <= 1'b0;
      unique case (op_i)
        OP_DECODE: begin
          if (!is_free && !too_large && !head_hit && !act_hit && sec_avail) begin
            next_sec_q  <= next_sec_q + NSW'(1);
            act_v_q[zc] <= 1'b1;
          end
        end
        OP_SEC_CHK:  if (!is_free && b_inc >= nblk) act_v_q[zq] <= 1'b0;
        OP_BLK_INIT: head_v_q[cls_q] <= 1'b1;
        OP_BLK_CHK:  if (app_empty) head_v_q[cls_fr] <= 1'b1;
        OP_TAKE:     if (will_fill && h_ptr == g_q && next_rd_q == g_q) head_v_q[cls_q] <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == OP_RESP && out_free) begin
      rsp_status_q <= err_q;
      rsp_handle_q <= (err_q == STATUS_OK) ? {sec8, blk8, item_q} : 32'd0;
      rsp_offset_q <= (err_q == STATUS_OK) ? off_sum[23:0] : 24'd0;
    end
    unique case (op_i)
      OP_ACCEPT: begin
        kind_q <= in_kind_i;
        size_q <= in_size_i;
        hnd_q  <= in_handle_i;
        item_q <= in_handle_i[15:0];
        err_q  <= STATUS_OK;
      end
      OP_DECODE: begin
        if (is_free) begin
          if (sec_ok) begin
            s_q   <= hsec[SECW-1:0];
            new_q <= 1'b0;
          end else err_q <= STATUS_BAD_HANDLE;
        end else begin
          cls_q <= cls_calc;
          if (too_large) err_q <= STATUS_TOO_LARGE;
          else if (head_hit) g_q <= head_q[cls_calc];
          else if (act_hit) begin
            s_q   <= act_q[zc];
            new_q <= 1'b0;
          end else if (sec_avail) begin
            s_q       <= next_sec_q[SECW-1:0];
            new_q     <= 1'b1;
            act_q[zc] <= next_sec_q[SECW-1:0];
          end else err_q <= STATUS_NO_SPACE;
        end
      end
      OP_SEC_CHK: begin
        if (!is_free)    g_q <= g_new;
        else if (blk_ok) g_q <= g_free;
        else             err_q <= STATUS_BAD_HANDLE;
      end
      OP_BLK_INIT: head_q[cls_q] <= g_q;
      OP_BLK_CHK: begin
        if (is_free) begin
          if (item_ok) begin
            cls_q <= cls_fr;
            if (app_empty) head_q[cls_fr] <= g_q;
          end else err_q <= STATUS_BAD_HANDLE;
        end else if (fh_hit) item_q <= {3'b000, fh_rd_q[ItemIdxW-1:0]};
        else if (bump_ok)    item_q <= {2'b00, bump_rd_q};
        else                 err_q  <= STATUS_NO_SPACE;
      end
      OP_TAKE: if (will_fill && h_ptr == g_q) head_q[cls_q] <= next_rd_q;
      default: ;
    endcase
  end

  // ring link write ports
  logic          nx_we, pv_we;
  logic [GW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, pv_ra;

  always_comb begin
    nx_we = 1'b0; nx_wa = g_q; nx_wd = g_q;
    pv_we = 1'b0; pv_wa = g_q; pv_wd = g_q;
    pv_ra = (op_i == OP_APP_RD) ? h_ptr : g_q;
    unique case (op_i)
      OP_BLK_INIT: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      OP_BLK_CHK: begin
        nx_we = app_empty;
        pv_we = app_empty;
      end
      OP_TAKE: begin
        // unlink a block that just filled
        nx_we = will_fill; nx_wa = prev_rd_q; nx_wd = next_rd_q;
        pv_we = will_fill; pv_wa = next_rd_q; pv_wd = prev_rd_q;
      end
      OP_APP_W1: begin
        nx_we = 1'b1; nx_wd = h_ptr;
        pv_we = 1'b1; pv_wd = prev_rd_q;
      end
      OP_APP_W2: begin
        nx_we = 1'b1; nx_wa = prev_rd_q;
        pv_we = 1'b1; pv_wa = h_ptr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (op_i == OP_BLK_RD) next_rd_q <= next_mem[g_q];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (op_i == OP_BLK_RD || op_i == OP_APP_RD) prev_rd_q <= prev_mem[pv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_BLK_INIT)                    fh_mem[g_q] <= NoItem;
    else if (op_i == OP_LINK_USE)               fh_mem[g_q] <= link_rd_q;
    else if (op_i == OP_BLK_CHK && is_free && item_ok) fh_mem[g_q] <= hnd_q[15:0];
    if (op_i == OP_BLK_RD) fh_rd_q <= fh_mem[g_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_BLK_INIT) bump_mem[g_q] <= 14'd0;
    else if (op_i == OP_BLK_CHK && !is_free && !fh_hit && bump_ok)
      bump_mem[g_q] <= bump_rd_q + 14'd1;
    if (op_i == OP_BLK_RD) bump_rd_q <= bump_mem[g_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_BLK_INIT)  cnt_mem[g_q] <= 14'd0;
    else if (op_i == OP_TAKE) cnt_mem[g_q] <= cnt_inc;
    else if (op_i == OP_BLK_CHK && is_free && item_ok) cnt_mem[g_q] <= cnt_rd_q - 14'd1;
    if (op_i == OP_BLK_RD) cnt_rd_q <= cnt_mem[g_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_BLK_INIT) cls_mem[g_q] <= cls_q;
    if (op_i == OP_BLK_RD)   cls_rd_q <= cls_mem[g_q];
  end

  // intrusive free list: one link word per item slot
  always_ff @(posedge clk_i) begin
    if (op_i == OP_BLK_CHK && is_free && item_ok)
      link_mem[LW'({g_q, hnd_q[ItemIdxW-1:0]})] <= fh_rd_q;
    if (op_i == OP_LINK_RD) link_rd_q <= link_mem[LW'({g_q, item_q[ItemIdxW-1:0]})];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_SEC_CHK && !is_free) sn_mem[s_q] <= b_inc;
    if (op_i == OP_SEC_RD) sn_rd_q <= sn_mem[s_q];
  end

  assign out_valid_o  = rsp_valid_q;
  assign out_status_o = rsp_status_q;
  assign out_handle_o = rsp_handle_q;
  assign out_offset_o = rsp_offset_q;

endmodule

[rtl/core/size_class_slab_allocator_unit.sv]
// Top level of the size-class slab allocator.
`timescale 1ns / 1ps
// Allocates and frees items from per-class rings of slab blocks. An allocate
// rounds its size to a power-of-two class (8 B to 2 MiB), takes an item from
// the head block of that class ring (free list first, then bump), and claims
// new blocks and sections on demand; a free pushes the item back and relinks
// a block that was full. One request is handled at a time: errors found at
// decode go straight to the result, and other requests walk a chain of
// dependent reads through the section table, the single-port block tables
// and the item link memory as they need them. A new request is accepted
// while the last result still waits in the output register. The block
// tables and the link memory have no reset; only entries already written
// are ever read.
module size_class_slab_allocator_unit
  import sca_pkg::*;
#(
  parameter int unsigned NUM_SECTIONS  = 4,
  parameter int unsigned SECTION_SHIFT = 22
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  sca_req_if.sink    req,
  sca_rsp_if.source  rsp
);

  op_e        op;
  dp_status_t dp_status;

  sca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .status_i   (dp_status),
    .op_o       (op)
  );

  sca_dp #(
    .NUM_SECTIONS  (NUM_SECTIONS),
    .SECTION_SHIFT (SECTION_SHIFT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (op),
    .in_kind_i    (req.kind),
    .in_size_i    (req.request_size),
    .in_handle_i  (req.free_handle),
    .out_ready_i  (rsp.ready),
    .out_valid_o  (rsp.valid),
    .out_status_o (rsp.status),
    .out_handle_o (rsp.handle),
    .out_offset_o (rsp.byte_offset),
    .status_o     (dp_status)
  );

endmodule
